// File: sv/lsfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsfb_pkg
// Types and constants shared by the line slope fit blocks.
// ----------------------------------------------------------------------------
package lsfb_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_LINE_OFFSET    = 3'd0;
   localparam logic [2:0] CSR_SLOPE_LOWER    = 3'd1;
   localparam logic [2:0] CSR_SLOPE_UPPER    = 3'd2;
   localparam logic [2:0] CSR_SLOPE_STEP     = 3'd3;
   localparam logic [2:0] CSR_MAX_ITERATIONS = 3'd4;

   // Register reset values.
   localparam logic signed [23:0] RST_LINE_OFFSET    = 24'sd40960;
   localparam logic signed [23:0] RST_SLOPE_LOWER    = 24'sd8192;
   localparam logic signed [23:0] RST_SLOPE_UPPER    = 24'sd32768;
   localparam logic [12:0]        RST_SLOPE_STEP     = 13'd4;
   localparam logic [7:0]         RST_MAX_ITERATIONS = 8'd100;

   // Evaluation phases of one bisection iteration.
   localparam logic [1:0] PHASE_LO      = 2'd0;
   localparam logic [1:0] PHASE_LO_STEP = 2'd1;
   localparam logic [1:0] PHASE_MID     = 2'd2;
   localparam logic [1:0] PHASE_MID_STEP = 2'd3;

   // Residual saturation limits, +-(2^31-1).
   localparam logic signed [39:0] RESID_HI = 40'sd2147483647;
   localparam logic signed [39:0] RESID_LO = -40'sd2147483647;
   localparam logic signed [31:0] RESID_CAP_POS = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] RESID_CAP_NEG = 32'sh8000_0001;

   // Request to the residual sum unit.
   typedef struct packed {
      logic               start;
      logic signed [24:0] slope;
      logic signed [23:0] offset;
   } chi2_ctrl_type;

   // Status back from the residual sum unit.
   typedef struct packed {
      logic        done;
      logic [63:0] sum;
   } chi2_stat_type;

endpackage
`default_nettype wire

// File: sv/line_slope_fit_bisection_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_slope_fit_bisection_core
// Least squares slope fit of x = a*t + offset by bisection over stored points.
// ----------------------------------------------------------------------------
// Points are loaded one transaction per cycle into an on-chip point RAM of
// MAX_POINTS entries; points beyond capacity are dropped and reported in
// rsp_tuser. The transaction with req_tlast set starts the fit, and the block
// is not ready for points until the fit is done. Each bisection iteration runs
// the shared residual sum pipeline four times (at the lower bound, the lower
// bound plus step, the midpoint and the midpoint plus step). Each run reads
// one point per cycle from the RAM, and a decision state closes the
// iteration. After the closing point the point channel is held off for the
// whole fit, and longer while an earlier result still waits in the output
// register. The result sits in an output register, so loading of the next
// point set may begin while it waits.
// ----------------------------------------------------------------------------
module line_slope_fit_bisection_core #(
   parameter int MAX_POINTS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Point channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // sample_time[23:0], sample_position[47:24]
   input  wire logic        req_tlast,   // last_point
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [31:0] rsp_tdata,   // fitted_slope[23:0], iterations_used[31:24]
   output logic             rsp_tuser,   // points_dropped
   // Configuration write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_data
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL_START,
      ST_EVAL_WAIT,
      ST_DECIDE,
      ST_FINISH
   } state_type;

   // Configuration registers.
   logic signed [23:0] offset_ff, lower_cfg_ff, upper_cfg_ff;
   logic [12:0]        step_ff;
   logic [7:0]         max_iter_ff;

   // Sequencer state.
   state_type          state_ff, state_in;
   logic [1:0]         phase_ff, phase_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               overflow_ff, overflow_in;
   logic signed [23:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [63:0]        c0_ff, c0_in;
   logic [1:0]         slo_ff, slo_in, smid_ff, smid_in;   // {nonzero, positive}
   logic [7:0]         iter_ff, iter_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [23:0] rsp_slope_ff, rsp_slope_in;
   logic [7:0]         rsp_iter_ff, rsp_iter_in;
   logic               rsp_drop_ff, rsp_drop_in;

   logic                    req_accept, has_room, wr_en;
   logic signed [24:0]      step_s, base_s, mid_sum;
   logic                    sum_gt, sum_lt, same_sign;
   logic signed [23:0]      new_lo, new_hi;
   logic signed [24:0]      diff_s;
   logic [24:0]             diff_abs;
   logic [7:0]              limit, iter_next;
   logic [AW-1:0]           rd_addr;
   logic [47:0]             rd_data;
   lsfb_pkg::chi2_ctrl_type chi2_ctrl;
   lsfb_pkg::chi2_stat_type chi2_stat;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign has_room   = (count_ff < CW'(MAX_POINTS));
   assign wr_en      = req_accept && has_room;
   assign csr_ready  = 1'b1;

   // Configuration writes must only be issued while the block is idle; the block itself does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= lsfb_pkg::RST_LINE_OFFSET;
         lower_cfg_ff <= lsfb_pkg::RST_SLOPE_LOWER;
         upper_cfg_ff <= lsfb_pkg::RST_SLOPE_UPPER;
         step_ff      <= lsfb_pkg::RST_SLOPE_STEP;
         max_iter_ff  <= lsfb_pkg::RST_MAX_ITERATIONS;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lsfb_pkg::CSR_LINE_OFFSET:    offset_ff    <= $signed(csr_data);
            lsfb_pkg::CSR_SLOPE_LOWER:    lower_cfg_ff <= $signed(csr_data);
            lsfb_pkg::CSR_SLOPE_UPPER:    upper_cfg_ff <= $signed(csr_data);
            lsfb_pkg::CSR_SLOPE_STEP:     step_ff      <= csr_data[12:0];
            lsfb_pkg::CSR_MAX_ITERATIONS: max_iter_ff  <= csr_data[7:0];
            default: begin
               // Writes to unknown indexes are ignored.
            end
         endcase
      end
   end

   // Point store: time in the low half, position in the high half.
   lsfb_ram #(
      .WIDTH (48),
      .DEPTH (MAX_POINTS)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The slope evaluated in this phase. The added step is kept at 25 bits,
   // so it never wraps.
   assign step_s = $signed({12'd0, step_ff});
   always_comb begin
      base_s = ((phase_ff == lsfb_pkg::PHASE_LO) || (phase_ff == lsfb_pkg::PHASE_LO_STEP))
               ? 25'(lo_ff) : 25'(mid_ff);
      chi2_ctrl.start  = (state_ff == ST_EVAL_START);
      chi2_ctrl.slope  = phase_ff[0] ? (base_s + step_s) : base_s;
      chi2_ctrl.offset = offset_ff;
   end

   lsfb_chi2_unit #(
      .MAX_POINTS (MAX_POINTS)
   ) u_chi2 (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (chi2_ctrl),
      .count   (count_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .stat    (chi2_stat)
   );

   // A zero iteration limit still runs one iteration.
   assign limit     = (max_iter_ff == 8'd0) ? 8'd1 : max_iter_ff;
   assign iter_next = iter_ff + 8'd1;
   assign mid_sum   = 25'(lo_ff) + 25'(hi_ff);
   assign sum_gt    = chi2_stat.sum > c0_ff;
   assign sum_lt    = chi2_stat.sum < c0_ff;

   // Both derivative signs nonzero and equal move the lower bound.
   assign same_sign = slo_ff[1] && smid_ff[1] && (slo_ff[0] == smid_ff[0]);
   assign new_lo    = same_sign ? mid_ff : lo_ff;
   assign new_hi    = same_sign ? hi_ff : mid_ff;
   assign diff_s    = 25'(new_lo) - 25'(new_hi);
   assign diff_abs  = diff_s[24] ? 25'(-diff_s) : 25'(diff_s);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      c0_in        = c0_ff;
      slo_in       = slo_ff;
      smid_in      = smid_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_slope_in = rsp_slope_ff;
      rsp_iter_in  = rsp_iter_ff;
      rsp_drop_in  = rsp_drop_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (has_room) begin
                  count_in = count_ff + CW'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_tlast) begin
                  lo_in    = lower_cfg_ff;
                  hi_in    = upper_cfg_ff;
                  mid_in   = lower_cfg_ff;
                  iter_in  = 8'd0;
                  phase_in = lsfb_pkg::PHASE_LO;
                  state_in = ST_EVAL_START;
               end
            end
         end
         ST_EVAL_START: begin
            state_in = ST_EVAL_WAIT;
         end
         ST_EVAL_WAIT: begin
            if (chi2_stat.done) begin
               unique case (phase_ff) inside
                  lsfb_pkg::PHASE_LO, lsfb_pkg::PHASE_MID: begin
                     c0_in    = chi2_stat.sum;
                     phase_in = phase_ff + 2'd1;
                     state_in = ST_EVAL_START;
                  end
                  lsfb_pkg::PHASE_LO_STEP: begin
                     slo_in   = {sum_gt || sum_lt, sum_gt};
                     mid_in   = mid_sum[24:1];
                     phase_in = lsfb_pkg::PHASE_MID;
                     state_in = ST_EVAL_START;
                  end
                  default: begin
                     smid_in  = {sum_gt || sum_lt, sum_gt};
                     state_in = ST_DECIDE;
                  end
               endcase
            end
         end
         ST_DECIDE: begin
            lo_in    = new_lo;
            hi_in    = new_hi;
            iter_in  = iter_next;
            phase_in = lsfb_pkg::PHASE_LO;
            if ((diff_abs >= 25'(step_ff)) && (iter_next < limit)) begin
               state_in = ST_EVAL_START;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Wait for the output register to drain before loading it.
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_slope_in = mid_ff;
               rsp_iter_in  = iter_ff;
               rsp_drop_in  = overflow_ff;
               count_in     = '0;
               overflow_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= lsfb_pkg::PHASE_LO;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         iter_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         mid_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         mid_ff       <= mid_in;
      end
      c0_ff        <= c0_in;
      slo_ff       <= slo_in;
      smid_ff      <= smid_in;
      rsp_slope_ff <= rsp_slope_in;
      rsp_iter_ff  <= rsp_iter_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_iter_ff, rsp_slope_ff};
   assign rsp_tuser  = rsp_drop_ff;

`ifndef SYNTHESIS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("stored point count beyond capacity");
   a_iter_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> (iter_ff < limit))
      else $error("iteration started beyond the limit");
   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && !rsp_valid_ff) |=>
         (rsp_valid_ff && count_ff == '0 && !overflow_ff && state_ff == ST_IDLE))
      else $error("result load did not clear the point set");
`endif

endmodule
`default_nettype wire

// File: sv/lsfb_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsfb_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lsfb_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// File: sv/lsfb_chi2_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsfb_chi2_unit
// Pipelined sum of saturated squared residuals over the stored points.
// ----------------------------------------------------------------------------
module lsfb_chi2_unit #(
   parameter int MAX_POINTS = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire lsfb_pkg::chi2_ctrl_type           ctrl,
   input  wire logic [$clog2(MAX_POINTS+1)-1:0]   count,
   output logic      [$clog2(MAX_POINTS)-1:0]     rd_addr,
   input  wire logic [47:0]                       rd_data,
   output lsfb_pkg::chi2_stat_type                stat
);

   localparam int AW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     issue_ff, issue_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic              issuing;
   logic signed [24:0] slope_ff, slope_in;
   logic signed [23:0] offset_ff, offset_in;
   logic signed [48:0] prod_ff, prod_in;
   logic signed [23:0] pos_ff, pos_in;
   logic signed [31:0] resid_ff, resid_in;
   logic [61:0]        sq_ff, sq_in;
   logic [63:0]        acc_ff, acc_in;
   logic signed [23:0] rd_time, rd_pos;
   logic signed [36:0] scaled;
   logic signed [39:0] pred_w, resid_w;
   logic signed [63:0] sq_full;
   logic [64:0]        sum_w;

   assign issuing = busy_ff && (issue_ff < count_ff);
   assign rd_addr = issue_ff[AW-1:0];
   assign rd_time = $signed(rd_data[23:0]);
   assign rd_pos  = $signed(rd_data[47:24]);

   always_comb begin
      busy_in   = busy_ff;
      issue_in  = issue_ff;
      count_in  = count_ff;
      slope_in  = slope_ff;
      offset_in = offset_ff;
      done_in   = 1'b0;
      if (ctrl.start) begin
         busy_in   = 1'b1;
         issue_in  = '0;
         count_in  = count;
         slope_in  = ctrl.slope;
         offset_in = ctrl.offset;
      end else if (issuing) begin
         issue_in = issue_ff + CW'(1);
      end else if (busy_ff && !(v1_ff || v2_ff || v3_ff || v4_ff)) begin
         busy_in = 1'b0;
         done_in = 1'b1;
      end

      // Product of slope and time, then floor to Q12.12.
      prod_in  = slope_ff * rd_time;
      pos_in   = rd_pos;

      scaled   = $signed(prod_ff[48:12]);
      pred_w   = scaled + offset_ff;
      resid_w  = pos_ff - pred_w;
      if (resid_w > lsfb_pkg::RESID_HI) begin
         resid_in = lsfb_pkg::RESID_CAP_POS;
      end else if (resid_w < lsfb_pkg::RESID_LO) begin
         resid_in = lsfb_pkg::RESID_CAP_NEG;
      end else begin
         resid_in = resid_w[31:0];
      end

      sq_full = resid_ff * resid_ff;
      sq_in   = sq_full[61:0];

      // The accumulator saturates at all ones.
      sum_w = {1'b0, acc_ff} + 65'(sq_ff);
      if (ctrl.start) begin
         acc_in = '0;
      end else if (v4_ff) begin
         acc_in = sum_w[64] ? '1 : sum_w[63:0];
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         issue_ff <= '0;
         count_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         v4_ff    <= 1'b0;
         acc_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         issue_ff <= issue_in;
         count_ff <= count_in;
         v1_ff    <= issuing && !ctrl.start;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         v4_ff    <= v3_ff;
         acc_ff   <= acc_in;
      end
      slope_ff  <= slope_in;
      offset_ff <= offset_in;
      prod_ff   <= prod_in;
      pos_ff    <= pos_in;
      resid_ff  <= resid_in;
      sq_ff     <= sq_in;
   end

   assign stat.done = done_ff;
   assign stat.sum  = acc_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> !busy_ff)
      else $error("residual sum started while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held for more than one cycle");
   a_acc_busy: assert property (@(posedge clock) disable iff (reset)
      v4_ff |-> busy_ff && !done_ff)
      else $error("accumulate outside a running sum");
`endif

endmodule
`default_nettype wire
